// ----- hdl/lec_pkg.sv -----
package lec_pkg;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [31:0] total_length;
  } out_item_t;

  // up to two converted bytes produced by one input item
  typedef struct packed {
    logic [1:0]  cnt;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        last;
    logic [31:0] total;
  } pair_t;

endpackage

// ----- hdl/line_ending_converter.sv -----
// path: an accepted item goes into the pair register, and its first byte
//   moves into the output register when that one is free or not stalled
// throughput: one one-byte item per cycle while the output is not stalled;
//   the single-byte output register makes a two-byte item hold off the next
// reset: rst_ni is asynchronous and active low; it clears the pending cr,
//   the byte count, pair count and out valid, and sets crlf_mode to lf mode
module line_ending_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: crlf_mode register
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lec_pkg::in_item_t  in_item_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lec_pkg::out_item_t out_item_o
);

  logic           crlf_mode_q;
  logic           take;
  logic           ready;
  lec_pkg::pair_t pair;

  // mode register, to be written only while the block is idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crlf_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      crlf_mode_q <= cfg_data_i;
    end
  end

  // an item is taken whenever the pair register is free or its last byte moves out now
  assign in_stall_o = !ready;
  assign take       = in_valid_i && ready;

  // conversion logic and stream state (held cr, previous cr, count)
  lec_conv u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .crlf_mode_i(crlf_mode_q),
    .take_i     (take),
    .in_item_i  (in_item_i),
    .pair_o     (pair)
  );

  // pair register feeding the output register one byte at a time
  lec_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (take),
    .pair_i     (pair),
    .out_stall_i(out_stall_i),
    .ready_o    (ready),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

// ----- hdl/lec_conv.sv -----
module lec_conv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              crlf_mode_i,
  input  logic              take_i,
  input  lec_pkg::in_item_t in_item_i,
  output lec_pkg::pair_t    pair_o
);

  logic        held_q, held_d;
  logic        prev_q, prev_d;
  logic [31:0] count_q, count_d;

  logic        is_cr, is_lf, pre_cr, emit_b;
  logic [32:0] sum;

  always_comb begin
    is_cr  = (in_item_i.in_byte == lec_pkg::CharCr);
    is_lf  = (in_item_i.in_byte == lec_pkg::CharLf);
    // crlf mode: flush a held cr, or insert one before a lone lf; lf mode: flush a held cr unless the byte is lf
    pre_cr = crlf_mode_i ? (held_q || (is_lf && !prev_q)) : (held_q && !is_lf);
    emit_b = crlf_mode_i || !(is_cr && !in_item_i.in_last);

    pair_o.cnt  = {1'b0, pre_cr} + {1'b0, emit_b};
    pair_o.b0   = pre_cr ? lec_pkg::CharCr : in_item_i.in_byte;
    pair_o.b1   = in_item_i.in_byte;
    pair_o.last = in_item_i.in_last;

    sum = {1'b0, count_q} + {31'd0, pair_o.cnt};
    pair_o.total = sum[32] ? lec_pkg::CountMax : sum[31:0];

    if (in_item_i.in_last) begin
      held_d  = 1'b0;
      prev_d  = 1'b0;
      count_d = '0;
    end else begin
      held_d  = !crlf_mode_i && is_cr;
      prev_d  = is_cr;
      count_d = pair_o.total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      prev_q  <= 1'b0;
      count_q <= '0;
    end else if (take_i) begin
      held_q  <= held_d;
      prev_q  <= prev_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- hdl/lec_ser.sv -----
module lec_ser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  lec_pkg::pair_t     pair_i,
  input  logic               out_stall_i,
  output logic               ready_o,
  output logic               out_valid_o,
  output lec_pkg::out_item_t out_item_o
);

  logic [1:0]         p_cnt_q, p_cnt_d;
  logic [7:0]         p_b0_q, p_b1_q;
  logic               p_last_q;
  logic [31:0]        p_total_q;
  logic               o_valid_q, o_valid_d;
  lec_pkg::out_item_t o_item_q, o_item_d;
  logic               move, fin;

  always_comb begin
    move    = (p_cnt_q != 2'd0) && (!o_valid_q || !out_stall_i);
    ready_o = (p_cnt_q == 2'd0) || ((p_cnt_q == 2'd1) && move);
    fin     = p_last_q && (p_cnt_q == 2'd1);

    o_item_d.out_byte     = p_b0_q;
    o_item_d.out_last     = fin;
    o_item_d.total_length = fin ? p_total_q : '0;

    if (move) begin
      o_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      o_valid_d = 1'b0;
    end else begin
      o_valid_d = o_valid_q;
    end

    if (load_i) begin
      p_cnt_d = pair_i.cnt;
    end else if (move) begin
      p_cnt_d = p_cnt_q - 2'd1;
    end else begin
      p_cnt_d = p_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_cnt_q   <= '0;
      o_valid_q <= 1'b0;
    end else begin
      p_cnt_q   <= p_cnt_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_b0_q    <= pair_i.b0;
      p_b1_q    <= pair_i.b1;
      p_last_q  <= pair_i.last;
      p_total_q <= pair_i.total;
    end else if (move) begin
      p_b0_q <= p_b1_q;
    end
    if (move) begin
      o_item_q <= o_item_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_item_o  = o_item_q;

endmodule

// ----- hdl/lec_checker.sv -----
module lec_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lec_pkg::out_item_t out_item_o
);

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed under stall");

  // length only on the final byte
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.out_last |-> out_item_o.total_length == 32'd0)
    else $error("total_length set on a non-final byte");

  // final byte counts itself
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.out_last |-> out_item_o.total_length != 32'd0)
    else $error("total_length zero on final byte");

endmodule

bind line_ending_converter lec_checker u_lec_checker (.*);

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic               cfg_we_i = 1'b0;
  logic               cfg_data_i = 1'b0;
  logic               in_valid_i = 1'b0;
  lec_pkg::in_item_t  in_item_i = '0;
  logic               out_stall_i = 1'b0;

  // block outputs
  logic               in_stall_o;
  logic               out_valid_o;
  lec_pkg::out_item_t out_item_o;

  line_ending_converter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // converter state as the testbench sees it
  logic        crlf_on;      // mirrors the crlf_mode register
  logic        pend_cr;      // lf mode: cr held back until the next byte
  logic        after_cr;     // last input byte of this stream was a cr
  logic [31:0] byte_count;   // output bytes of the current stream, saturating

  lec_pkg::out_item_t expected_bytes[$];

  int errors = 0;
  int items_sent = 0;

  // traffic shaping knobs, changed per phase
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int burst_left = 0;

  // work out the output bytes of one accepted input item
  task automatic convert_item(input lec_pkg::in_item_t it);
    logic [7:0]         outs[2];
    int                 n;
    logic               prior_cr;
    lec_pkg::out_item_t res;
    n = 0;
    prior_cr = after_cr;
    if (!crlf_on) begin
      // lf mode: a held cr survives only if the next byte is not lf
      if (pend_cr) begin
        pend_cr = 1'b0;
        if (it.in_byte != lec_pkg::CharLf) begin
          outs[n] = lec_pkg::CharCr;
          n++;
        end
      end
      // a cr mid-stream is held; a cr that ends the stream goes straight out
      if (it.in_byte == lec_pkg::CharCr && !it.in_last) begin
        pend_cr = 1'b1;
      end else begin
        outs[n] = it.in_byte;
        n++;
      end
    end else begin
      // cr still held from lf mode: flush it, and it counts as a preceding cr
      if (pend_cr) begin
        pend_cr = 1'b0;
        outs[n] = lec_pkg::CharCr;
        n++;
        prior_cr = 1'b1;
      end
      if (it.in_byte == lec_pkg::CharLf && !prior_cr) begin
        outs[n] = lec_pkg::CharCr;
        n++;
      end
      outs[n] = it.in_byte;
      n++;
    end
    after_cr = (it.in_byte == lec_pkg::CharCr);
    for (int k = 0; k < n; k++) begin
      if (byte_count != lec_pkg::CountMax) begin
        byte_count++;
      end
      res.out_byte = outs[k];
      res.out_last = it.in_last && (k == n - 1);
      res.total_length = res.out_last ? byte_count : 32'd0;
      expected_bytes.push_back(res);
    end
    // end of stream clears everything but the mode
    if (it.in_last) begin
      pend_cr = 1'b0;
      after_cr = 1'b0;
      byte_count = '0;
    end
  endtask

  // present one item and hold it until the block takes it
  task automatic send_item(input logic [7:0] b, input logic l);
    lec_pkg::in_item_t it;
    int                gap;
    bit                took;
    it.in_byte = b;
    it.in_last = l;
    // bursts of random length, with random gaps between them when gaps_on is set
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    // stall is stable mid-cycle since every input changes at the rising edge
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    convert_item(it);
    items_sent++;
  endtask

  // drop valid, let every expected byte come out, then let the pipe settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    // an item that only loads a held cr gives no output, so wait out latency
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    crlf_on = m;
    cfg_we_i <= 1'b0;
  endtask

  // result checker: a result counts as taken when valid is high and stall is low,
  // so it is sampled at the falling edge, where both are stable
  initial begin
    lec_pkg::out_item_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected item byte %h last %b len %0d", $time,
                   out_item_o.out_byte, out_item_o.out_last, out_item_o.total_length);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_item_o.out_byte !== want.out_byte
              || out_item_o.out_last !== want.out_last
              || out_item_o.total_length !== want.total_length) begin
            $display({"%0t: mismatch expected byte %h last %b len %0d,",
                      " actual byte %h last %b len %0d"},
                     $time, want.out_byte, want.out_last, want.total_length,
                     out_item_o.out_byte, out_item_o.out_last, out_item_o.total_length);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall: a random 32-bit pattern, reloaded when the 6-bit age counter wraps
  logic [31:0] stall_pattern = '0;
  logic [5:0]  stall_age = '0;

  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = '0;
        1: stall_pattern = $urandom() & $urandom();
        2: stall_pattern = $urandom();
        default: stall_pattern = $urandom() | $urandom();
      endcase
    end
    stall_age = stall_age + 1'b1;
    out_stall_i <= stalls_on && stall_pattern[stall_age[4:0]];
  end

  // text-like byte: line endings are common, rest is anything
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return lec_pkg::CharCr;
      3, 4, 5: return lec_pkg::CharLf;
      6: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // lf mode: crlf pairs, lone cr, cr runs, cr at stream end, extreme bytes
  task automatic test_lf_mode();
    write_mode(1'b0);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_item(8'h00, 1'b0);
    send_item(lec_pkg::CharCr, 1'b0);
    send_item(lec_pkg::CharLf, 1'b0);
    send_item(lec_pkg::CharCr, 1'b0);
    send_item(lec_pkg::CharCr, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(lec_pkg::CharCr, 1'b1);
    // single-byte stream
    send_item(lec_pkg::CharLf, 1'b1);
    // held cr dropped by an lf that ends the stream
    send_item(lec_pkg::CharCr, 1'b0);
    send_item(lec_pkg::CharLf, 1'b1);
  endtask

  // crlf mode: lf at stream start, lone lf, existing crlf, cr and lf at end
  task automatic test_crlf_mode();
    write_mode(1'b1);
    send_item(lec_pkg::CharLf, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(lec_pkg::CharLf, 1'b0);
    send_item(lec_pkg::CharCr, 1'b0);
    send_item(lec_pkg::CharLf, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(lec_pkg::CharCr, 1'b1);
    send_item(lec_pkg::CharLf, 1'b1);
  endtask

  // switch to crlf mode while a cr is held back from lf mode
  task automatic test_mode_switch();
    write_mode(1'b0);
    send_item(8'h78, 1'b0);
    send_item(lec_pkg::CharCr, 1'b0);
    write_mode(1'b1);
    send_item(lec_pkg::CharLf, 1'b1);
    write_mode(1'b0);
    send_item(lec_pkg::CharCr, 1'b0);
    write_mode(1'b1);
    send_item(8'h41, 1'b1);
  endtask

  // random streams over phases with different modes and traffic shapes
  task automatic test_random_streams();
    int   phase;
    int   phase_end;
    int   len;
    int   cut;
    bit   noise;
    logic l;
    phase = 0;
    while (items_sent < 1200) begin
      // alternate modes so both extremes get long stretches
      write_mode(phase[0]);
      gaps_on = (phase % 3) != 0;
      stalls_on = (phase % 4) != 1;
      phase_end = items_sent + 150;
      while (items_sent < phase_end && items_sent < 1200) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
        noise = ($urandom_range(0, 7) == 0);
        // sometimes flip the mode partway through a stream
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : -1;
        for (int i = 0; i < len; i++) begin
          if (i == cut) begin
            write_mode(!crlf_on);
          end
          if (noise) begin
            l = ($urandom_range(0, 5) == 0) || (i == len - 1);
            send_item(8'($urandom_range(0, 255)), l);
          end else begin
            send_item(pick_text_byte(), i == len - 1);
          end
        end
      end
      phase++;
    end
  endtask

  initial begin
    crlf_on = 1'b0;
    pend_cr = 1'b0;
    after_cr = 1'b0;
    byte_count = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lf_mode();
    test_crlf_mode();
    test_mode_switch();
    test_random_streams();

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, ends a run that hangs with a fail
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
